// ===== design/wtosc_pkg.sv =====
`default_nettype none
package wtosc_pkg;

  localparam int PHASE_W    = 32;
  localparam int FRAC_BITS  = 22;
  localparam int IDX_W      = PHASE_W - FRAC_BITS;
  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [VOL_W-1:0]   VOLUME_UNITY    = 16'd32768;
  localparam logic [PHASE_W-1:0] RESET_INCREMENT = 32'd42852365;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 1'd1;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDA,
    S_RDB,
    S_MUL1,
    S_MUL2,
    S_OUT
  } osc_state_t;

endpackage
`default_nettype wire

// ===== design/wavetable_interp_oscillator.sv =====
// Tick item: steps RDA, RDB, MUL1, MUL2, OUT; next item taken only after OUT, set by the
//   single read port of the table (two reads per sample) and two multiplier stages.
// Load item: written as accepted if index < TABLE_DEPTH, next taken in the following cycle.
// A tick runs on while an earlier result waits, and holds in its last stage until then.
// Reset (rst_n low, synchronous): phase and handshakes cleared, registers to their reset
//   values, then a clearing pass zeroes every table entry with in_stall high.
`default_nettype none
module wavetable_interp_oscillator #(
  parameter int TABLE_DEPTH = wtosc_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_opcode,
  input  wire logic [wtosc_pkg::IDX_W-1:0]           in_entry_index,
  input  wire logic signed [wtosc_pkg::SAMPLE_W-1:0] in_entry_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0]      out_sample_out,
  input  wire logic                                  cfg_we,
  input  wire logic [wtosc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [wtosc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wtosc_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam int PROD1_W = SAMPLE_W + 1 + FRAC_BITS + 1;
  localparam int PROD2_W = SAMPLE_W + VOL_W + 1;

  // Reduce the phase index mod depth (TABLE_DEPTH >= 16): compare and subtract multiples.
  function automatic logic [IDX_W-1:0] reduce_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    r = idx;
    for (int k = 5; k >= 0; k--) begin
      if ((TABLE_DEPTH << k) <= IDX_MAX) begin
        if (32'(r) >= (TABLE_DEPTH << k)) begin
          r = r - IDX_W'(TABLE_DEPTH << k);
        end
      end
    end
    return r;
  endfunction

  osc_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [SAMPLE_W-1:0] mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  logic [AW-1:0]         clr_cnt_r;
  logic [PHASE_W-1:0]    phase_acc_r;
  logic [PHASE_W-1:0]    phase_inc_r;
  logic [VOL_W-1:0]      volume_r;
  logic [FRAC_BITS-1:0]  frac_r;
  logic [AW-1:0]         base_r;
  logic [AW-1:0]         next_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [PROD1_W-1:0]  prod1_r;
  logic signed [PROD2_W-1:0]  prod2_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic                    in_acc;
  logic                    load_ok;
  logic [IDX_W-1:0]        base_w;
  logic [IDX_W:0]          next_w;
  logic signed [SAMPLE_W:0] diff_w;
  logic signed [PROD1_W-FRAC_BITS-1:0] step_w;
  logic signed [PROD1_W-FRAC_BITS-1:0] interp_w;
  logic [VOL_W-1:0]        vol_wr;
  logic                    out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = (32'(in_entry_index) < TABLE_DEPTH);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign base_w   = reduce_idx(phase_acc_r[PHASE_W-1:FRAC_BITS]);
  assign next_w   = {1'b0, base_w} + 1'b1;
  assign diff_w   = $signed({rd_r[SAMPLE_W-1], rd_r}) - $signed({a_r[SAMPLE_W-1], a_r});
  assign step_w   = prod1_r[PROD1_W-1:FRAC_BITS];
  assign interp_w = step_w + a_r;
  assign vol_wr   = (cfg_data[VOL_W-1:0] > VOLUME_UNITY) ? VOLUME_UNITY : cfg_data[VOL_W-1:0];

  // Table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = AW'(in_entry_index);
    mem_wd    = in_entry_value;
    mem_re    = 1'b0;
    mem_ra    = base_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_LOAD) begin
            mem_we = load_ok;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end
      S_RDA: begin
        mem_re    = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        mem_re    = 1'b1;
        mem_ra    = next_r;
        state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      phase_acc_r <= '0;
      phase_inc_r <= RESET_INCREMENT;
      volume_r    <= VOLUME_UNITY;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_INC: phase_inc_r <= cfg_data[PHASE_W-1:0];
          REG_VOLUME:    volume_r    <= vol_wr;
          default:       ;
        endcase
      end
      // advance the phase as the tick is taken
      if (state_r == S_IDLE && in_acc && in_opcode == OP_TICK) begin
        phase_acc_r <= phase_acc_r + phase_inc_r;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      frac_r <= phase_acc_r[FRAC_BITS-1:0];
      base_r <= AW'(base_w);
      next_r <= (32'(next_w) == TABLE_DEPTH) ? '0 : AW'(next_w);
    end
    if (state_r == S_RDB) begin
      a_r <= rd_r;
    end
    if (state_r == S_MUL1) begin
      prod1_r <= $signed({1'b0, frac_r}) * diff_w;
    end
    if (state_r == S_MUL2) begin
      prod2_r <= $signed(interp_w[SAMPLE_W-1:0]) * $signed({1'b0, volume_r});
    end
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= prod2_r[SAMPLE_W+14:15];
    end
  end

endmodule
`default_nettype wire
